### sv/kfd_pkg.sv
// Shared types and constants for the KISS frame deframer.
package kfd_pkg;

    localparam logic [7:0] KISS_FEND  = 8'hC0;
    localparam logic [7:0] KISS_FESC  = 8'hDB;
    localparam logic [7:0] KISS_TFEND = 8'hDC;
    localparam logic [7:0] KISS_TFESC = 8'hDD;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [11:0] MIN_GOOD_EXCL     = 12'd2;
    localparam logic [11:0] DEFAULT_FRAME_LEN = 12'd1152;
    localparam int          COUNT_MAX         = 4095;
    localparam logic [15:0] TOTAL_MAX         = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_error;
    } kfd_in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [10:0] byte_index;
        logic [11:0] frame_length;
        logic        frame_good;
        logic [15:0] line_errors;
        logic [15:0] overruns;
    } kfd_out_t;

    typedef struct packed {
        logic        escape_mark;
        logic        error_mark;
        logic [11:0] byte_count;
        logic [15:0] line_error_total;
        logic [15:0] overrun_total;
    } kfd_state_t;

endpackage

### sv/kiss_frame_deframer.sv
// Top level of the KISS receive deframer: input register, frame state and result register.
//
// This block strips KISS framing from a stream of received serial bytes. Each request on
// the input carries one byte and a line-error flag from the UART. Escaped bytes are
// restored, every payload byte that is kept comes out with its position in the frame,
// and each FEND produces an end-of-frame result with the frame length and a good flag
// (no error seen and more than two bytes). Bytes with a line error, FESC bytes, bytes
// dropped after an error and overrun bytes produce no result. The block takes one byte
// per clock cycle when the output is not stalled. An accepted byte is held in the input
// register until it moves on, and its result is loaded into the result register as it
// does so; while the result register is full and not taken, a byte with a result stays
// held in the input register.
// The decode of a byte is a single pass of logic against the frame state, which is what
// lets the next byte follow directly. The frame limit is max_len_reg clamped to
// BUFFER_DEPTH and to 4095; write the limit only while no bytes are in flight.
module kiss_frame_deframer #(
    parameter int BUFFER_DEPTH = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [11:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  kfd_pkg::kfd_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output kfd_pkg::kfd_out_t  out_data
);

    // Hard cap on the frame limit, from the buffer size and the 12-bit byte counter.
    localparam int LimitCap = (BUFFER_DEPTH < kfd_pkg::COUNT_MAX) ? BUFFER_DEPTH
                                                                   : kfd_pkg::COUNT_MAX;
    localparam logic [11:0] LIMIT_CAP = 12'(LimitCap);

    logic [11:0]         max_len_reg;
    logic                in_valid_reg;
    kfd_pkg::kfd_in_t    in_item_reg;
    kfd_pkg::kfd_state_t state_reg;
    kfd_pkg::kfd_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    kfd_pkg::kfd_out_t   out_item_reg;
    kfd_pkg::kfd_out_t   step_result;
    logic                step_emit;
    logic [11:0]         frame_limit;
    logic                advance;

    assign frame_limit = (max_len_reg > LIMIT_CAP) ? LIMIT_CAP : max_len_reg;

    kfd_decode u_decode (
        .item        (in_item_reg),
        .state_cur   (state_reg),
        .frame_limit (frame_limit),
        .state_next  (state_next),
        .result      (step_result),
        .emit        (step_emit)
    );

    // A held byte moves on when it produces nothing or the result register can take it.
    assign advance  = in_valid_reg && (!step_emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        if (advance && step_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= kfd_pkg::DEFAULT_FRAME_LEN;
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance && step_emit)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

### sv/kfd_decode.sv
// Per-byte KISS decode: unescaping, frame bookkeeping and result formation.
module kfd_decode (
    input  kfd_pkg::kfd_in_t    item,
    input  kfd_pkg::kfd_state_t state_cur,
    input  logic [11:0]         frame_limit,
    output kfd_pkg::kfd_state_t state_next,
    output kfd_pkg::kfd_out_t   result,
    output logic                emit
);

    always_comb
    begin
        logic [7:0] b;
        b          = item.data_byte;
        state_next = state_cur;
        result     = '0;
        emit       = 1'b0;

        if (item.line_error)
        begin
            // Count a damaged frame only once.
            if (!state_cur.error_mark && state_cur.line_error_total != kfd_pkg::TOTAL_MAX)
            begin
                state_next.line_error_total = state_cur.line_error_total + 16'd1;
            end
            state_next.error_mark = 1'b1;
        end
        else if (b == kfd_pkg::KISS_FEND)
        begin
            emit                = 1'b1;
            result.kind         = kfd_pkg::KIND_END;
            result.frame_length = state_cur.byte_count;
            result.frame_good   = !state_cur.error_mark &&
                                  (state_cur.byte_count > kfd_pkg::MIN_GOOD_EXCL);
            state_next.escape_mark = 1'b0;
            state_next.error_mark  = 1'b0;
            state_next.byte_count  = '0;
        end
        else if (b == kfd_pkg::KISS_FESC)
        begin
            state_next.escape_mark = 1'b1;
        end
        else
        begin
            if (b == kfd_pkg::KISS_TFESC || b == kfd_pkg::KISS_TFEND)
            begin
                if (state_cur.escape_mark)
                begin
                    b = (b == kfd_pkg::KISS_TFESC) ? kfd_pkg::KISS_FESC : kfd_pkg::KISS_FEND;
                end
                state_next.escape_mark = 1'b0;
            end

            if (!state_cur.error_mark)
            begin
                if (state_cur.byte_count < frame_limit)
                begin
                    emit                  = 1'b1;
                    result.kind           = kfd_pkg::KIND_DATA;
                    result.payload_byte   = b;
                    result.byte_index     = state_cur.byte_count[10:0];
                    state_next.byte_count = state_cur.byte_count + 12'd1;
                end
                else
                begin
                    if (state_cur.overrun_total != kfd_pkg::TOTAL_MAX)
                    begin
                        state_next.overrun_total = state_cur.overrun_total + 16'd1;
                    end
                    state_next.error_mark = 1'b1;
                end
            end
        end

        result.line_errors = state_next.line_error_total;
        result.overruns    = state_next.overrun_total;
    end

endmodule

### sv/kfd_checker.sv
// Port-level assertions for the KISS frame deframer, bound to the top level.
module kfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input kfd_pkg::kfd_out_t  out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == kfd_pkg::KIND_END |->
            out_data.payload_byte == 8'd0 && out_data.byte_index == 11'd0)
        else $error("end-of-frame result carries byte fields");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == kfd_pkg::KIND_DATA |->
            out_data.frame_length == 12'd0 && !out_data.frame_good)
        else $error("payload result carries frame fields");

    a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_good |->
            out_data.frame_length > kfd_pkg::MIN_GOOD_EXCL)
        else $error("good frame too short");

endmodule

bind kiss_frame_deframer kfd_checker u_kfd_checker (.*);
